>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion helpers shared by the palette pixel scaler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition a implies condition c in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

// Condition a never holds.
`define ASSERT_NEVER(lbl, clk, rst, a, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(a)) else $error(msg);

`endif

>>> design/pps_pkg.sv
// ---------------------------------------------------------------------------
// pps_pkg
// Shared types, register codes and position helpers of the pixel scaler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_PAL_BG    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAL_OBJ_A = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAL_OBJ_B = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCALING   = 2'd3;

  // Scaling modes
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_STRETCH = 2'd1;
  localparam logic [1:0] MODE_ASPECT  = 2'd2;

  // Palette selects
  localparam logic [1:0] PAL_SEL_BG    = 2'd0;
  localparam logic [1:0] PAL_SEL_OBJ_A = 2'd1;

  // Field widths
  localparam int CODE_W  = 8;
  localparam int COORD_W = 8;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int COLOR_W = 16;
  localparam int PAL_W   = 64;
  localparam int SPOS_W  = 10;

  // Command queue sizing
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Floor-by-six reciprocal: (m * 171) >> 10 is exact for m below 511
  localparam int RECIP6      = 171;
  localparam int RECIP6_SH   = 10;
  localparam int RECIP_PROD_W = 17;

  // One classified source pixel, ready for the back end
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [X_W-1:0]     x0;
    logic [Y_W-1:0]     y0;
    logic               two_x;
    logic               two_y;
  } pps_desc_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } pps_qstat_t;

  // floor(m / 6) for values below 384
  function automatic logic [5:0] div6(input logic [8:0] m);
    logic [RECIP_PROD_W-1:0] prod;
    prod = RECIP_PROD_W'(m) * RECIP_PROD_W'(RECIP6);
    return prod[RECIP6_SH+5:RECIP6_SH];
  endfunction

  // n + floor(n/2) + ceil(n/6)
  function automatic logic [SPOS_W-1:0] scaled_pos(input logic [COORD_W-1:0] n);
    logic [5:0] q;
    q = div6({1'b0, n} + 9'd5);
    return SPOS_W'(n) + SPOS_W'(n[COORD_W-1:1]) + SPOS_W'(q);
  endfunction

  // Odd or a multiple of six
  function automatic logic pos_repeats(input logic [COORD_W-1:0] n);
    logic [5:0]         q;
    logic [COORD_W-1:0] six_q;
    q     = div6({1'b0, n});
    six_q = COORD_W'({q, 2'b00}) + COORD_W'({q, 1'b0});
    return n[0] | (six_q == n);
  endfunction

endpackage

`default_nettype wire

>>> design/palette_pixel_scaler_core.sv
// ---------------------------------------------------------------------------
// palette_pixel_scaler_core
// Palette lookup and nearest-neighbor scaling of source pixels to screen.
// ---------------------------------------------------------------------------
// Usage:
//   Pulse start with pixel_code, column and line while busy is low; the pixel
//   is taken at that edge. Each screen write appears on screen_x, screen_y and
//   color for exactly one cycle with result_valid high; last marks the final
//   write of a pixel. The receiver cannot stall the results.
//   Configuration is written through cfg_valid/cfg_ready with cfg_index and
//   cfg_data (0 palette_bg, 1 palette_obj_a, 2 palette_obj_b, 3 scaling mode);
//   write only while no pixel is in flight. cfg_ready is always high.
// A pixel taken passes the front stage, the command queue, the current-pixel
//   register and the result register. Throughput: one write per cycle while
//   pixels are queued, set by the emitter; a pixel makes 1 write in normal mode,
//   2 or 4 in stretch mode, 1 to 4 in keep-aspect mode. A 4-entry queue and the
//   front stage absorb bursts; busy rises when they together hold 4 pixels.
// Reset (rst, synchronous): clears the palettes and mode, empties the queue
//   and drops any pixel in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palette_pixel_scaler_core #(
  parameter int SRC_WIDTH     = 160,
  parameter int SRC_HEIGHT    = 144,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pps_pkg::CODE_W-1:0]    pixel_code,
  input  wire logic [pps_pkg::COORD_W-1:0]   column,
  input  wire logic [pps_pkg::COORD_W-1:0]   line,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pps_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [pps_pkg::PAL_W-1:0]     cfg_data,
  output logic                               result_valid,
  output logic [pps_pkg::X_W-1:0]            screen_x,
  output logic [pps_pkg::Y_W-1:0]            screen_y,
  output logic [pps_pkg::COLOR_W-1:0]        color,
  output logic                               last
);
  import pps_pkg::*;

  logic       push;
  logic       pop;
  pps_desc_t  push_desc;
  pps_desc_t  head_desc;
  pps_qstat_t qstat;

  // Registers accept a write every cycle
  assign cfg_ready = 1'b1;

  pps_front #(
    .SRC_WIDTH     (SRC_WIDTH),
    .SRC_HEIGHT    (SRC_HEIGHT),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pixel_code (pixel_code),
    .column     (column),
    .line       (line),
    .cfg_valid  (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .qstat      (qstat),
    .push       (push),
    .push_desc  (push_desc)
  );

  pps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .qstat     (qstat)
  );

  pps_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .head_desc    (head_desc),
    .pop          (pop),
    .result_valid (result_valid),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .color        (color),
    .last         (last)
  );

endmodule

`default_nettype wire

>>> design/pps_front.sv
// ---------------------------------------------------------------------------
// pps_front
// Holds the configuration, accepts source pixels and classifies each one
// into a colour, a base screen position and its repeat flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_front #(
  parameter int SRC_WIDTH     = 160,
  parameter int SRC_HEIGHT    = 144,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pps_pkg::CODE_W-1:0]    pixel_code,
  input  wire logic [pps_pkg::COORD_W-1:0]   column,
  input  wire logic [pps_pkg::COORD_W-1:0]   line,
  input  wire logic                          cfg_valid,
  input  wire logic [pps_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [pps_pkg::PAL_W-1:0]     cfg_data,
  input  wire pps_pkg::pps_qstat_t           qstat,
  output logic                               push,
  output pps_pkg::pps_desc_t                 push_desc
);
  import pps_pkg::*;

  localparam int SCALED_SRC_W = SRC_WIDTH + SRC_WIDTH / 2 + (SRC_WIDTH + 5) / 6;
  localparam int CX = (SCREEN_WIDTH > SRC_WIDTH) ? (SCREEN_WIDTH - SRC_WIDTH) / 2 : 0;
  localparam int CY = (SCREEN_HEIGHT > SRC_HEIGHT) ? (SCREEN_HEIGHT - SRC_HEIGHT) / 2 : 0;
  localparam int KX = (SCREEN_WIDTH > SCALED_SRC_W) ? (SCREEN_WIDTH - SCALED_SRC_W) / 2 : 0;

  logic [PAL_W-1:0]   palette_bg;
  logic [PAL_W-1:0]   palette_obj_a;
  logic [PAL_W-1:0]   palette_obj_b;
  logic [1:0]         scaling_select;
  logic               stage_valid;
  pps_desc_t          stage_desc;
  pps_desc_t          desc_next;
  logic [PAL_W-1:0]   pal;
  logic [SPOS_W-1:0]  sx;
  logic [SPOS_W-1:0]  sy;
  logic               accept;
  logic [QCNT_W:0]    occupancy;

  // Hold off new pixels while the queue plus the stage could overflow
  assign occupancy = {1'b0, qstat.count} + (QCNT_W + 1)'(stage_valid);
  assign busy      = occupancy >= (QCNT_W + 1)'(QDEPTH);
  assign accept    = start & ~busy;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_bg     <= '0;
      palette_obj_a  <= '0;
      palette_obj_b  <= '0;
      scaling_select <= MODE_NORMAL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PAL_BG:    palette_bg     <= cfg_data;
        REG_PAL_OBJ_A: palette_obj_a  <= cfg_data;
        REG_PAL_OBJ_B: palette_obj_b  <= cfg_data;
        REG_SCALING:   scaling_select <= cfg_data[1:0];
        default:       ;
      endcase
    end
  end

  // Classify the incoming pixel
  always_comb begin
    case (pixel_code[5:4])
      PAL_SEL_BG:    pal = palette_bg;
      PAL_SEL_OBJ_A: pal = palette_obj_a;
      default:       pal = palette_obj_b;
    endcase
    desc_next.color = pal[{pixel_code[1:0], 4'b0000} +: COLOR_W];

    sx = scaled_pos(column);
    sy = scaled_pos(line);

    unique case (scaling_select)
      MODE_STRETCH: begin
        desc_next.x0    = {column, 1'b0};
        desc_next.two_x = 1'b1;
        desc_next.y0    = sy[Y_W-1:0];
        desc_next.two_y = pos_repeats(line);
      end
      MODE_ASPECT: begin
        desc_next.x0    = X_W'(KX) + sx[X_W-1:0];
        desc_next.two_x = pos_repeats(column);
        desc_next.y0    = sy[Y_W-1:0];
        desc_next.two_y = pos_repeats(line);
      end
      default: begin
        desc_next.x0    = X_W'(CX) + X_W'(column);
        desc_next.two_x = 1'b0;
        desc_next.y0    = Y_W'(CY) + Y_W'(line);
        desc_next.two_y = 1'b0;
      end
    endcase
  end

  // Register the classified pixel, then hand it to the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
    if (accept) begin
      stage_desc <= desc_next;
    end
  end

  assign push      = stage_valid;
  assign push_desc = stage_desc;

endmodule

`default_nettype wire

>>> design/pps_queue.sv
// ---------------------------------------------------------------------------
// pps_queue
// Short command queue between the classifying front and the emitting back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pps_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire pps_pkg::pps_desc_t  push_desc,
  input  wire logic                pop,
  output pps_pkg::pps_desc_t       head_desc,
  output pps_pkg::pps_qstat_t      qstat
);
  import pps_pkg::*;

  pps_desc_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Store new commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign head_desc   = entries[rd_ptr];
  assign qstat.count = count;
  assign qstat.empty = (count == '0);

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && !pop && count == QCNT_W'(QDEPTH), "queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && count == '0, "queue underflow")

endmodule

`default_nettype wire

>>> design/pps_back.sv
// ---------------------------------------------------------------------------
// pps_back
// Takes classified pixels from the queue and emits one screen write per
// cycle while pixels are queued, line by line and left to right.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pps_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pps_pkg::pps_qstat_t         qstat,
  input  wire pps_pkg::pps_desc_t          head_desc,
  output logic                             pop,
  output logic                             result_valid,
  output logic [pps_pkg::X_W-1:0]          screen_x,
  output logic [pps_pkg::Y_W-1:0]          screen_y,
  output logic [pps_pkg::COLOR_W-1:0]      color,
  output logic                             last
);
  import pps_pkg::*;

  logic      cur_valid;
  pps_desc_t cur;
  logic      ix;
  logic      iy;
  logic      row_end;
  logic      beat_last;

  assign row_end   = ix | ~cur.two_x;
  assign beat_last = row_end & (iy | ~cur.two_y);

  // Fetch the next pixel when idle or on the final beat of the current one
  assign pop = ~qstat.empty & (~cur_valid | beat_last);

  // Walk the beats of the current pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      ix        <= 1'b0;
      iy        <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      ix        <= 1'b0;
      iy        <= 1'b0;
    end else if (cur_valid) begin
      if (beat_last) begin
        cur_valid <= 1'b0;
      end else if (row_end) begin
        ix <= 1'b0;
        iy <= 1'b1;
      end else begin
        ix <= 1'b1;
      end
    end
    if (pop) begin
      cur <= head_desc;
    end
  end

  // Drive the registered result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cur_valid;
    end
    screen_x <= cur.x0 + X_W'(ix);
    screen_y <= cur.y0 + Y_W'(iy);
    color    <= cur.color;
    last     <= beat_last;
  end

  `ASSERT_NEXT(a_beats_contiguous, clk, rst, result_valid && !last, result_valid, "pixel beats split")
  `ASSERT_IMPLIES(a_ix_needs_two_x, clk, rst, cur_valid && ix, cur.two_x, "column repeat without flag")
  `ASSERT_IMPLIES(a_iy_needs_two_y, clk, rst, cur_valid && iy, cur.two_y, "line repeat without flag")

endmodule

`default_nettype wire

>>> verif/palette_pixel_scaler_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_pixel_scaler_checker
// Watches the register, pixel and screen-write channels of the scaler. Keeps
// its own copy of the palettes and the scaling mode, works out the screen
// writes of every pixel taken, and compares each write beat in order.
// ---------------------------------------------------------------------------

module palette_pixel_scaler_checker
  import pps_pkg::*;
#(
  parameter int SRC_WIDTH     = 160,
  parameter int SRC_HEIGHT    = 144,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [CODE_W-1:0]    pixel_code,
  input  logic [COORD_W-1:0]   column,
  input  logic [COORD_W-1:0]   line,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [PAL_W-1:0]     cfg_data,
  input  logic                 result_valid,
  input  logic [X_W-1:0]       screen_x,
  input  logic [Y_W-1:0]       screen_y,
  input  logic [COLOR_W-1:0]   color,
  input  logic                 last,
  output int                   mismatches,
  output int                   outstanding,
  output int                   writes_checked
);

  typedef struct packed {
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } screen_write_t;

  screen_write_t       pending_writes[$];
  logic [PAL_W-1:0]    bg_colors;
  logic [PAL_W-1:0]    obj_a_colors;
  logic [PAL_W-1:0]    obj_b_colors;
  logic [1:0]          scale_mode;

  // n + floor(n/2) + ceil(n/6)
  function automatic int scaled_coord(input int n);
    return n + n / 2 + (n + 5) / 6;
  endfunction

  // Odd positions and multiples of six get a second row or column
  function automatic bit doubled(input int n);
    return (n % 2 == 1) || (n % 6 == 0);
  endfunction

  function automatic int centring(input int screen_size, input int image_size);
    return (screen_size > image_size) ? (screen_size - image_size) / 2 : 0;
  endfunction

  // Queue every screen write of one pixel, line by line, columns ascending
  task automatic queue_writes(input logic [CODE_W-1:0] code,
                              input logic [COORD_W-1:0] col,
                              input logic [COORD_W-1:0] lin);
    logic [PAL_W-1:0]   pal;
    logic [COLOR_W-1:0] shade_color;
    int                 x0;
    int                 y0;
    int                 nx;
    int                 ny;
    screen_write_t      w;
    case (code[5:4])
      PAL_SEL_BG:    pal = bg_colors;
      PAL_SEL_OBJ_A: pal = obj_a_colors;
      default:       pal = obj_b_colors;  // select 3 clamps to palette 2
    endcase
    shade_color = pal[COLOR_W*code[1:0] +: COLOR_W];
    if (scale_mode == MODE_STRETCH || scale_mode == MODE_ASPECT) begin
      y0 = scaled_coord(lin);
      ny = doubled(lin) ? 2 : 1;
      if (scale_mode == MODE_STRETCH) begin
        x0 = 2 * col;
        nx = 2;
      end else begin
        x0 = centring(SCREEN_WIDTH, scaled_coord(SRC_WIDTH)) + scaled_coord(col);
        nx = doubled(col) ? 2 : 1;
      end
    end else begin
      // normal and the unused mode code: one centered write
      x0 = centring(SCREEN_WIDTH, SRC_WIDTH) + col;
      y0 = centring(SCREEN_HEIGHT, SRC_HEIGHT) + lin;
      nx = 1;
      ny = 1;
    end
    for (int j = 0; j < ny; j++) begin
      for (int i = 0; i < nx; i++) begin
        w.x     = X_W'(x0 + i);
        w.y     = Y_W'(y0 + j);
        w.color = shade_color;
        w.last  = (i == nx - 1) && (j == ny - 1);
        pending_writes.push_back(w);
      end
    end
  endtask

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch_beats
    screen_write_t seen;
    screen_write_t want;
    if (rst) begin
      pending_writes.delete();
      bg_colors      = '0;
      obj_a_colors   = '0;
      obj_b_colors   = '0;
      scale_mode     = MODE_NORMAL;
      mismatches     = 0;
      writes_checked = 0;
      outstanding   <= 0;
    end else begin
      // compare a write beat against the oldest prediction
      if (result_valid) begin
        seen = '{x: screen_x, y: screen_y, color: color, last: last};
        if (pending_writes.size() == 0) begin
          $display("%0t: unexpected write, expected none, got x=%0h y=%0h color=%0h last=%0b",
                   $time, seen.x, seen.y, seen.color, seen.last);
          mismatches++;
        end else begin
          want = pending_writes.pop_front();
          if (seen.x != want.x) report_field("screen_x", want.x, seen.x);
          if (seen.y != want.y) report_field("screen_y", want.y, seen.y);
          if (seen.color != want.color) report_field("color", want.color, seen.color);
          if (seen.last != want.last) report_field("last", want.last, seen.last);
        end
        writes_checked++;
      end

      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PAL_BG:    bg_colors    = cfg_data;
          REG_PAL_OBJ_A: obj_a_colors = cfg_data;
          REG_PAL_OBJ_B: obj_b_colors = cfg_data;
          REG_SCALING:   scale_mode   = cfg_data[1:0];
          default: ;
        endcase
      end

      // predict the writes of a pixel taken at this edge
      if (start && !busy) queue_writes(pixel_code, column, line);

      outstanding <= pending_writes.size();
    end
  end

endmodule

>>> verif/palette_pixel_scaler_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_pixel_scaler_core_test
// Drives pixels and register settings into the scaler across all scaling
// modes, with random sender gaps, and reports the verdict of the checker.
// ---------------------------------------------------------------------------

module palette_pixel_scaler_core_test;
  import pps_pkg::*;

  localparam int WATCHDOG_LIMIT = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_PIXELS   = 15;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [CODE_W-1:0]    pixel_code;
  logic [COORD_W-1:0]   column;
  logic [COORD_W-1:0]   line;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [PAL_W-1:0]     cfg_data;
  logic                 result_valid;
  logic [X_W-1:0]       screen_x;
  logic [Y_W-1:0]       screen_y;
  logic [COLOR_W-1:0]   color;
  logic                 last;

  int         mismatches;
  int         outstanding;
  int         writes_checked;
  int         pixels_sent;
  int         settings_loaded;
  int         mode_pixels[4];
  int         stall_cycles;
  logic [1:0] cur_mode;

  palette_pixel_scaler_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_code   (pixel_code),
    .column       (column),
    .line         (line),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .color        (color),
    .last         (last)
  );

  palette_pixel_scaler_checker write_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .pixel_code     (pixel_code),
    .column         (column),
    .line           (line),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .screen_x       (screen_x),
    .screen_y       (screen_y),
    .color          (color),
    .last           (last),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .writes_checked (writes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold start high until the pixel beat is taken; start stays high after
  task automatic send_pixel(input logic [CODE_W-1:0] code,
                            input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] lin);
    start      <= 1'b1;
    pixel_code <= code;
    column     <= col;
    line       <= lin;
    do @(posedge clk); while (busy);
    pixels_sent++;
    mode_pixels[cur_mode]++;
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and wait until every predicted write has come out
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PAL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load all four registers back to back; call only when drained
  task automatic load_settings(input logic [PAL_W-1:0] bg, input logic [PAL_W-1:0] obj_a,
                               input logic [PAL_W-1:0] obj_b, input logic [1:0] scale);
    write_reg(REG_PAL_BG, bg);
    write_reg(REG_PAL_OBJ_A, obj_a);
    write_reg(REG_PAL_OBJ_B, obj_b);
    write_reg(REG_SCALING, PAL_W'(scale));
    cfg_valid <= 1'b0;
    cur_mode = scale;
    settings_loaded++;
  endtask

  function automatic logic [PAL_W-1:0] random_palette();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly in-frame coordinates, sometimes the full byte range
  task automatic send_random(input bit quiet);
    logic [CODE_W-1:0]  code;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] lin;
    code = CODE_W'($urandom_range(0, 255));
    col  = COORD_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 159));
    lin  = COORD_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 143));
    send_pixel(code, col, lin);
    if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 11));
  endtask

  // Stop the run when nothing has been accepted or written for too long
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [1:0] scale;
    bit         quiet;
    rst        = 1'b1;
    start      = 1'b0;
    pixel_code = '0;
    column     = '0;
    line       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_PAL_BG;
    cfg_data   = '0;
    cur_mode   = MODE_NORMAL;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero palettes, normal mode
    send_pixel(8'h3F, 8'd159, 8'd143);
    drain();

    // normal mode: corners, palette select 3, coordinates past the frame
    load_settings(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888,
                  64'h9999_AAAA_BBBB_CCCC, MODE_NORMAL);
    send_pixel(8'h00, 8'd0, 8'd0);
    send_pixel(8'hFF, 8'd159, 8'd143);
    send_pixel(8'h15, 8'd80, 8'd72);
    send_pixel(8'hE2, 8'd255, 8'd255);
    drain();

    // stretch: repeated and single lines, wrap of the line position
    load_settings(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                  64'hF0F0_0F0F_A5A5_5A5A, MODE_STRETCH);
    send_pixel(8'h21, 8'd0, 8'd0);
    send_pixel(8'h33, 8'd1, 8'd1);
    send_pixel(8'h02, 8'd2, 8'd2);
    send_pixel(8'hC0, 8'd159, 8'd143);
    send_pixel(8'h10, 8'd255, 8'd255);
    drain();

    // keep aspect: odd, multiple-of-six and plain columns, past the frame
    load_settings(64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF,
                  64'h8000_0001_7FFE_C003, MODE_ASPECT);
    send_pixel(8'h01, 8'd0, 8'd0);
    send_pixel(8'h12, 8'd1, 8'd1);
    send_pixel(8'h23, 8'd2, 8'd4);
    send_pixel(8'h30, 8'd6, 8'd6);
    send_pixel(8'h31, 8'd159, 8'd143);
    send_pixel(8'h20, 8'd160, 8'd144);
    send_pixel(8'hFF, 8'd255, 8'd255);
    drain();

    // unused mode code behaves as normal
    load_settings('1, '1, '1, MODE_UNUSED);
    send_pixel(8'h3A, 8'd12, 8'd200);
    drain();

    // random phases; the last one runs with no sender gaps
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       scale = MODE_ASPECT;
        1:       scale = MODE_STRETCH;
        2:       scale = MODE_NORMAL;
        3:       scale = MODE_ASPECT;
        4:       scale = 2'($urandom_range(0, 3));
        default: scale = MODE_STRETCH;
      endcase
      quiet = (p == RANDOM_PHASES - 1);
      if (p == 0) begin
        load_settings('1, '1, '1, scale);
      end else begin
        load_settings(random_palette(), random_palette(), random_palette(), scale);
      end
      for (int i = 0; i < PHASE_PIXELS; i++) send_random(quiet);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d pixels over %0d register settings", pixels_sent, settings_loaded);
    $display("Summary: normal %0d, stretch %0d, aspect %0d, unused mode %0d pixels",
             mode_pixels[MODE_NORMAL], mode_pixels[MODE_STRETCH],
             mode_pixels[MODE_ASPECT], mode_pixels[MODE_UNUSED]);
    $display("Summary: %0d screen writes compared, %0d mismatches", writes_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
